[hw/rtl/assert_macros.svh]
// Concurrent assertion helpers; clk and rst_n are taken from the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define HD_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

`define HD_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`else

`define HD_ASSERT_IMP(lbl, a, b)
`define HD_ASSERT_NXT(lbl, a, b)

`endif

`endif

[hw/rtl/hd_pkg.sv]
`default_nettype none

package hd_pkg;

    localparam int CORDIC_STAGES = 32;
    localparam int SQRT_STAGES   = 31;

    localparam int ANG_W   = 34;
    localparam int UNIT_W  = 33;
    localparam int MAG_W   = 33;
    localparam int RPU_W   = 31;
    localparam int LO_W    = 17;
    localparam int HI_W    = MAG_W - LO_W;
    localparam int PP_W    = LO_W + RPU_W;
    localparam int SUM_W   = MAG_W + RPU_W;
    localparam int Q_W     = 31;
    localparam int SQ_N_W  = 61;
    localparam int THETA_W = 31;

    localparam int RADIUS_W = 24;
    localparam int RAD200_W = 32;
    localparam int PROD_W   = RAD200_W + THETA_W;
    localparam int DIST_W   = 34;

    localparam int LANES     = 4;
    localparam int SQ_LANES  = 2;

    localparam int LANE_LAT_A = 0;
    localparam int LANE_LAT_B = 1;
    localparam int LANE_DLAT  = 2;
    localparam int LANE_DLON  = 3;
    localparam int SQ_X       = 0;
    localparam int SQ_Y       = 1;

    localparam logic [RPU_W-1:0] RAD_PER_UNIT = 31'd2012227627;

    typedef logic signed [ANG_W-1:0] ang_t;

    localparam ang_t PI_Q30      = 34'sd3373259426;
    localparam ang_t HALF_PI_Q30 = 34'sd1686629713;
    localparam ang_t TWO_PI_Q30  = 34'sd6746518852;
    localparam ang_t GAIN_Q30    = 34'sd652032874;
    localparam ang_t ONE_ANG     = 34'sd1073741824;

    localparam logic [Q_W-1:0]      ONE_Q30      = 31'h4000_0000;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd6371000;
    localparam logic [DIST_W-1:0]   DIST_MAX     = '1;

    typedef struct packed {
        logic flip;
        ang_t z;
    } prep_t;

    typedef struct packed {
        ang_t c;
        ang_t s;
    } trig_t;

    function automatic ang_t atan_step(input int i);
        ang_t r;
        case (i)
            0: r = 34'sd843314857;
            1: r = 34'sd497837829;
            2: r = 34'sd263043837;
            3: r = 34'sd133525159;
            4: r = 34'sd67021687;
            5: r = 34'sd33543516;
            6: r = 34'sd16775851;
            7: r = 34'sd8388437;
            8: r = 34'sd4194283;
            9: r = 34'sd2097149;
            default: r = (i <= 30) ? (ang_t'(1) <<< (30 - i)) : '0;
        endcase
        return r;
    endfunction

    // Q30 product, rounded on the magnitude
    function automatic ang_t mulq(input ang_t a, input ang_t b);
        logic [31:0] ua;
        logic [31:0] ub;
        logic [63:0] p;
        ang_t        r;
        ua = a[ANG_W-1] ? 32'(-a) : 32'(a);
        ub = b[ANG_W-1] ? 32'(-b) : 32'(b);
        p  = 64'(ua) * 64'(ub) + 64'h2000_0000;
        r  = ang_t'(p >> 30);
        return (a[ANG_W-1] ^ b[ANG_W-1]) ? -r : r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/hd_angle_prep.sv]
`default_nettype none

module hd_angle_prep
    import hd_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_vld,
    input  wire logic [LANES-1:0][UNIT_W-1:0]  unit,
    input  wire logic [LANES-1:0]              half,
    output logic                               out_vld,
    output prep_t     [LANES-1:0]              prep
);

    logic [2:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], in_vld};
        end
    end

    assign out_vld = vld_reg[2];

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic              neg_reg, half_reg;
        logic [PP_W-1:0]   pp_lo_reg;
        logic [PP_W-1:0]   pp_hi_reg;
        ang_t              z_reg;
        prep_t             prep_reg;
        logic [MAG_W-1:0]  mag;
        logic [SUM_W-1:0]  sum;
        logic [SUM_W-1:0]  rnd;
        ang_t              z_next;
        ang_t              w;
        prep_t             prep_next;

        assign mag = unit[l][UNIT_W-1] ? MAG_W'(-unit[l]) : MAG_W'(unit[l]);

        always_ff @(posedge clk)
        begin
            neg_reg   <= unit[l][UNIT_W-1];
            half_reg  <= half[l];
            pp_lo_reg <= PP_W'(mag[LO_W-1:0]) * PP_W'(RAD_PER_UNIT);
            pp_hi_reg <= PP_W'(mag[MAG_W-1:LO_W]) * PP_W'(RAD_PER_UNIT);
        end

        always_comb
        begin
            sum = (SUM_W'(pp_hi_reg) << LO_W) + SUM_W'(pp_lo_reg)
                + (half_reg ? (SUM_W'(1) << 30) : (SUM_W'(1) << 29));
            rnd = half_reg ? (sum >> 31) : (sum >> 30);
            z_next = neg_reg ? -ang_t'(rnd) : ang_t'(rnd);
        end

        always_ff @(posedge clk)
        begin
            z_reg <= z_next;
        end

        // wrap into [-pi, pi], then fold into [-pi/2, pi/2]
        always_comb
        begin
            w = z_reg;
            if (z_reg > PI_Q30)
            begin
                w = z_reg - TWO_PI_Q30;
            end
            else if (z_reg < -PI_Q30)
            begin
                w = z_reg + TWO_PI_Q30;
            end
            prep_next.z    = w;
            prep_next.flip = 1'b0;
            if (w > HALF_PI_Q30)
            begin
                prep_next.z    = PI_Q30 - w;
                prep_next.flip = 1'b1;
            end
            else if (w < -HALF_PI_Q30)
            begin
                prep_next.z    = -PI_Q30 - w;
                prep_next.flip = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            prep_reg <= prep_next;
        end

        assign prep[l] = prep_reg;
    end

endmodule

`default_nettype wire

[hw/rtl/hd_sincos.sv]
`default_nettype none

module hd_sincos
    import hd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_vld,
    input  prep_t     [LANES-1:0]   prep,
    output logic                    out_vld,
    output trig_t     [LANES-1:0]   trig
);

    logic vld_reg [CORDIC_STAGES];
    ang_t x_reg   [CORDIC_STAGES][LANES];
    ang_t y_reg   [CORDIC_STAGES][LANES];
    ang_t z_reg   [CORDIC_STAGES][LANES];
    logic f_reg   [CORDIC_STAGES][LANES];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        logic vi;
        if (i == 0) begin : g_first
            assign vi = in_vld;
        end
        else begin : g_rest
            assign vi = vld_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else
            begin
                vld_reg[i] <= vi;
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            ang_t xi, yi, zi;
            logic fi;
            if (i == 0) begin : g_first
                assign xi = GAIN_Q30;
                assign yi = '0;
                assign zi = prep[l].z;
                assign fi = prep[l].flip;
            end
            else begin : g_rest
                assign xi = x_reg[i-1][l];
                assign yi = y_reg[i-1][l];
                assign zi = z_reg[i-1][l];
                assign fi = f_reg[i-1][l];
            end

            always_ff @(posedge clk)
            begin
                f_reg[i][l] <= fi;
                if (zi >= 0)
                begin
                    x_reg[i][l] <= xi - (yi >>> i);
                    y_reg[i][l] <= yi + (xi >>> i);
                    z_reg[i][l] <= zi - atan_step(i);
                end
                else
                begin
                    x_reg[i][l] <= xi + (yi >>> i);
                    y_reg[i][l] <= yi - (xi >>> i);
                    z_reg[i][l] <= zi + atan_step(i);
                end
            end
        end
    end

    logic  out_vld_reg;
    trig_t trig_reg [LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= vld_reg[CORDIC_STAGES-1];
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_out
        always_ff @(posedge clk)
        begin
            trig_reg[l].c <= f_reg[CORDIC_STAGES-1][l] ? -x_reg[CORDIC_STAGES-1][l]
                                                       : x_reg[CORDIC_STAGES-1][l];
            trig_reg[l].s <= y_reg[CORDIC_STAGES-1][l];
        end
        assign trig[l] = trig_reg[l];
    end

    assign out_vld = out_vld_reg;

endmodule

`default_nettype wire

[hw/rtl/hd_isqrt.sv]
`default_nettype none

module hd_isqrt
    import hd_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_vld,
    input  wire logic [SQ_LANES-1:0][Q_W-1:0]  rad,
    output logic                               out_vld,
    output logic      [SQ_LANES-1:0][Q_W-1:0]  root
);

    logic              vld_reg [SQRT_STAGES];
    logic [SQ_N_W-1:0] n_reg   [SQRT_STAGES][SQ_LANES];
    logic [SQ_N_W-1:0] res_reg [SQRT_STAGES][SQ_LANES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        localparam logic [SQ_N_W-1:0] BIT = SQ_N_W'(1) << (SQ_N_W - 1 - 2 * k);
        logic vi;
        if (k == 0) begin : g_first
            assign vi = in_vld;
        end
        else begin : g_rest
            assign vi = vld_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vi;
            end
        end

        for (genvar l = 0; l < SQ_LANES; l++) begin : g_lane
            logic [SQ_N_W-1:0] ni, resi, t;
            if (k == 0) begin : g_first
                assign ni   = {rad[l], 30'b0};
                assign resi = '0;
            end
            else begin : g_rest
                assign ni   = n_reg[k-1][l];
                assign resi = res_reg[k-1][l];
            end
            assign t = resi + BIT;

            always_ff @(posedge clk)
            begin
                if (ni >= t)
                begin
                    n_reg[k][l]   <= ni - t;
                    res_reg[k][l] <= (resi >> 1) + BIT;
                end
                else
                begin
                    n_reg[k][l]   <= ni;
                    res_reg[k][l] <= resi >> 1;
                end
            end
        end
    end

    for (genvar l = 0; l < SQ_LANES; l++) begin : g_out
        assign root[l] = res_reg[SQRT_STAGES-1][l][Q_W-1:0];
    end

    assign out_vld = vld_reg[SQRT_STAGES-1];

endmodule

`default_nettype wire

[hw/rtl/hd_atan2.sv]
`default_nettype none

module hd_atan2
    import hd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_vld,
    input  wire logic [Q_W-1:0]      x_in,
    input  wire logic [Q_W-1:0]      y_in,
    output logic                     out_vld,
    output logic      [THETA_W-1:0]  theta
);

    logic vld_reg [CORDIC_STAGES];
    ang_t x_reg   [CORDIC_STAGES];
    ang_t y_reg   [CORDIC_STAGES];
    ang_t z_reg   [CORDIC_STAGES];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        logic vi;
        ang_t xi, yi, zi;
        if (i == 0) begin : g_first
            assign vi = in_vld;
            assign xi = ang_t'(x_in);
            assign yi = ang_t'(y_in);
            assign zi = '0;
        end
        else begin : g_rest
            assign vi = vld_reg[i-1];
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else
            begin
                vld_reg[i] <= vi;
            end
        end

        always_ff @(posedge clk)
        begin
            if (yi >= 0)
            begin
                x_reg[i] <= xi + (yi >>> i);
                y_reg[i] <= yi - (xi >>> i);
                z_reg[i] <= zi + atan_step(i);
            end
            else
            begin
                x_reg[i] <= xi - (yi >>> i);
                y_reg[i] <= yi + (xi >>> i);
                z_reg[i] <= zi - atan_step(i);
            end
        end
    end

    logic               out_vld_reg;
    logic [THETA_W-1:0] theta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= vld_reg[CORDIC_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        theta_reg <= z_reg[CORDIC_STAGES-1][ANG_W-1] ? '0
                                                     : z_reg[CORDIC_STAGES-1][THETA_W-1:0];
    end

    assign out_vld = out_vld_reg;
    assign theta   = theta_reg;

endmodule

`default_nettype wire

[hw/rtl/haversine_distance_core.sv]
// Channel | Signals                              | Beat taken when
// --------+--------------------------------------+-----------------------
// input   | start, busy, lat_a/lon_a/lat_b/lon_b | start && !busy
// config  | cfg_valid, cfg_ready, cfg_data       | cfg_valid && cfg_ready
// result  | done, distance_cm                    | done (one cycle)
//
// Fully pipelined: one beat per cycle.
// Most of the latency comes from the two 32-stage CORDIC chains and the 31-stage square root.
// busy stays low; the receiver cannot stall, so nothing ever holds the pipe.
// Reset clears the valid bits and loads the radius with 6371000 m.
`default_nettype none

`include "assert_macros.svh"

module haversine_distance_core
    import hd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic signed [30:0]    lat_a,
    input  wire logic signed [31:0]    lon_a,
    input  wire logic signed [30:0]    lat_b,
    input  wire logic signed [31:0]    lon_b,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [RADIUS_W-1:0]   cfg_data,
    output logic                       done,
    output logic      [DIST_W-1:0]     distance_cm
);

    logic [RADIUS_W-1:0] radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            radius_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // input beat
    logic               in_vld_reg;
    logic signed [30:0] lat_a_reg, lat_b_reg;
    logic signed [31:0] lon_a_reg, lon_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        lat_a_reg <= lat_a;
        lon_a_reg <= lon_a;
        lat_b_reg <= lat_b;
        lon_b_reg <= lon_b;
    end

    logic [LANES-1:0][UNIT_W-1:0] unit;
    logic [LANES-1:0]             half;

    always_comb
    begin
        unit[LANE_LAT_A] = UNIT_W'(lat_a_reg);
        unit[LANE_LAT_B] = UNIT_W'(lat_b_reg);
        unit[LANE_DLAT]  = UNIT_W'(lat_b_reg) - UNIT_W'(lat_a_reg);
        unit[LANE_DLON]  = UNIT_W'(lon_b_reg) - UNIT_W'(lon_a_reg);
        half             = '0;
        half[LANE_DLAT]  = 1'b1;
        half[LANE_DLON]  = 1'b1;
    end

    logic                   prep_vld;
    prep_t  [LANES-1:0]     prep;
    logic                   trig_vld;
    trig_t  [LANES-1:0]     trig;

    hd_angle_prep u_prep (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (in_vld_reg),
        .unit    (unit),
        .half    (half),
        .out_vld (prep_vld),
        .prep    (prep)
    );

    hd_sincos u_sincos (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (prep_vld),
        .prep    (prep),
        .out_vld (trig_vld),
        .trig    (trig)
    );

    // haversine term
    logic           m1_vld_reg, m2_vld_reg, m3_vld_reg;
    ang_t           p1_reg, p2_reg, p3_reg, p1b_reg, p4_reg;
    logic [Q_W-1:0] a_reg;
    ang_t           a_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
        end
        else
        begin
            m1_vld_reg <= trig_vld;
            m2_vld_reg <= m1_vld_reg;
            m3_vld_reg <= m2_vld_reg;
        end
    end

    assign a_sum = p1b_reg + p4_reg;

    always_ff @(posedge clk)
    begin
        p1_reg  <= mulq(trig[LANE_DLAT].s, trig[LANE_DLAT].s);
        p2_reg  <= mulq(trig[LANE_LAT_A].c, trig[LANE_LAT_B].c);
        p3_reg  <= mulq(trig[LANE_DLON].s, trig[LANE_DLON].s);
        p1b_reg <= p1_reg;
        p4_reg  <= mulq(p2_reg, p3_reg);
        if (a_sum < 0)
        begin
            a_reg <= '0;
        end
        else if (a_sum > ONE_ANG)
        begin
            a_reg <= ONE_Q30;
        end
        else
        begin
            a_reg <= a_sum[Q_W-1:0];
        end
    end

    logic [SQ_LANES-1:0][Q_W-1:0] rad;
    logic [SQ_LANES-1:0][Q_W-1:0] root;
    logic                         root_vld;
    logic                         theta_vld;
    logic [THETA_W-1:0]           theta;

    always_comb
    begin
        rad[SQ_X] = ONE_Q30 - a_reg;
        rad[SQ_Y] = a_reg;
    end

    hd_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (m3_vld_reg),
        .rad     (rad),
        .out_vld (root_vld),
        .root    (root)
    );

    hd_atan2 u_atan2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (root_vld),
        .x_in    (root[SQ_X]),
        .y_in    (root[SQ_Y]),
        .out_vld (theta_vld),
        .theta   (theta)
    );

    // scale to centimetres
    logic                prod_vld_reg, done_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [DIST_W-1:0]   dist_reg;
    logic [RAD200_W-1:0] rad200;
    logic [PROD_W-1:0]   rnd;

    assign rad200 = RAD200_W'(radius_reg) * RAD200_W'(200);
    assign rnd    = (prod_reg + (PROD_W'(1) << 29)) >> 30;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= theta_vld;
            done_reg     <= prod_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(rad200) * PROD_W'(theta);
        dist_reg <= (rnd > PROD_W'(DIST_MAX)) ? DIST_MAX : rnd[DIST_W-1:0];
    end

    assign done        = done_reg;
    assign distance_cm = dist_reg;

    `HD_ASSERT_NXT(a_cfg_write, cfg_valid && cfg_ready, radius_reg == $past(cfg_data))
    `HD_ASSERT_NXT(a_in_capture, start && !busy, in_vld_reg)
    `HD_ASSERT_NXT(a_out_strobe, prod_vld_reg, done)
    `HD_ASSERT_IMP(a_out_source, done, $past(prod_vld_reg))

endmodule

`default_nettype wire

[tb/haversine_distance_core_tb.sv]
`default_nettype none

module haversine_distance_core_tb;
    import hd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  LATENCY  = 106;
    localparam int  N_RANDOM = 420;
    localparam longint LAT_LIM = 900000000;
    localparam longint LON_LIM = 1800000000;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic signed [30:0]    lat_a;
    logic signed [31:0]    lon_a;
    logic signed [30:0]    lat_b;
    logic signed [31:0]    lon_b;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [RADIUS_W-1:0]   cfg_data;
    logic                  done;
    logic [DIST_W-1:0]     distance_cm;

    haversine_distance_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .lat_a      (lat_a),
        .lon_a      (lon_a),
        .lat_b      (lat_b),
        .lon_b      (lon_b),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .done       (done),
        .distance_cm(distance_cm)
    );

    logic [DIST_W-1:0]   exp_dist_q[$];
    logic [RADIUS_W-1:0] radius_m;
    int                  n_mismatch;
    int                  n_errors;
    int                  n_sent;
    int                  n_checked;
    int                  n_radius;
    int                  burst_left;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ---------------------------------------------------------------- predictor
    localparam longint unsigned PI_Q60   = 64'h3243F6A8885A308D;
    localparam longint unsigned RPU      = (PI_Q60 + 64'd900000000) / 64'd1800000000;
    localparam longint PI_ANG            = longint'((PI_Q60 + (64'd1 << 29)) >> 30);
    localparam longint HALF_PI_ANG       = longint'((PI_Q60 + (64'd1 << 30)) >> 31);
    localparam longint TWO_PI_ANG        = longint'((PI_Q60 + (64'd1 << 28)) >> 29);
    localparam longint ONE_ANG_Q         = 64'sd1 << 30;

    function automatic longint atan_q30(input int i);
        longint tbl[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                            33543516, 16775851, 8388437, 4194283, 2097149};
        if (i < 10)
            return tbl[i];
        if (i <= 30)
            return 64'sd1 << (30 - i);
        return 0;
    endfunction

    function automatic longint units_to_rad(input longint u, input int sh);
        longint unsigned mag;
        longint unsigned r;
        mag = (u < 0) ? longint'(-u) : longint'(u);
        r = (mag * RPU + (64'd1 << (sh - 1))) >> sh;
        return (u < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint q30_mul(input longint a, input longint b);
        longint unsigned ua;
        longint unsigned ub;
        longint unsigned r;
        ua = (a < 0) ? longint'(-a) : longint'(a);
        ub = (b < 0) ? longint'(-b) : longint'(b);
        r = (ua * ub + (64'd1 << 29)) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    task automatic rotate_sincos(input longint ang, output longint c, output longint s);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        z = ang;
        x = 652032874;
        y = 0;
        flip = 1'b0;
        while (z > PI_ANG)
            z -= TWO_PI_ANG;
        while (z < -PI_ANG)
            z += TWO_PI_ANG;
        if (z > HALF_PI_ANG)
        begin
            z = PI_ANG - z;
            flip = 1'b1;
        end
        else if (z < -HALF_PI_ANG)
        begin
            z = -PI_ANG - z;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_q30(i);
            end
            else
            begin
                x += dx; y -= dy; z += atan_q30(i);
            end
        end
        c = flip ? -x : x;
        s = y;
    endtask

    function automatic longint int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint vector_atan2(input longint y0, input longint x0);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = x0;
        y = y0;
        z = 0;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += atan_q30(i);
            end
            else
            begin
                x -= dx; y += dy; z -= atan_q30(i);
            end
        end
        return z;
    endfunction

    task automatic great_circle_cm(input longint la, input longint oa, input longint lb,
                                   input longint ob, input logic [RADIUS_W-1:0] rad,
                                   output logic [DIST_W-1:0] span_cm);
        longint c1, s1, c2, s2, cdl, sdl, cdo, sdo, hav, theta;
        longint unsigned d;
        rotate_sincos(units_to_rad(la, 30), c1, s1);
        rotate_sincos(units_to_rad(lb, 30), c2, s2);
        rotate_sincos(units_to_rad(lb - la, 31), cdl, sdl);
        rotate_sincos(units_to_rad(ob - oa, 31), cdo, sdo);
        hav = q30_mul(sdl, sdl) + q30_mul(q30_mul(c1, c2), q30_mul(sdo, sdo));
        if (hav < 0)
            hav = 0;
        if (hav > ONE_ANG_Q)
            hav = ONE_ANG_Q;
        theta = vector_atan2(int_sqrt(longint'(hav) << 30),
                             int_sqrt(longint'(ONE_ANG_Q - hav) << 30));
        if (theta < 0)
            theta = 0;
        d = (longint'(rad) * 64'd200 * longint'(theta) + (64'd1 << 29)) >> 30;
        if (d > 64'h3_FFFF_FFFF)
            d = 64'h3_FFFF_FFFF;
        span_cm = d[DIST_W-1:0];
    endtask

    // ---------------------------------------------------------------- driving
    task automatic send_pair(input logic signed [30:0] la, input logic signed [31:0] oa,
                             input logic signed [30:0] lb, input logic signed [31:0] ob);
        int gap;
        logic [DIST_W-1:0] d;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                start = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        lat_a = la;
        lon_a = oa;
        lat_b = lb;
        lon_b = ob;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        great_circle_cm(la, oa, lb, ob, radius_m, d);
        exp_dist_q = {exp_dist_q, d};
        n_sent++;
        burst_left--;
    endtask

    task automatic write_radius(input logic [RADIUS_W-1:0] value);
        @(negedge clk);
        start = 1'b0;
        while (exp_dist_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        radius_m = value;
        n_radius++;
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_data  = RADIUS_W'($urandom());
    endtask

    function automatic logic signed [30:0] rand_lat(input bit raw);
        if (raw)
            return 31'($urandom());
        return 31'(longint'($urandom_range(0, 1800000000)) - LAT_LIM);
    endfunction

    function automatic logic signed [31:0] rand_lon(input bit raw);
        if (raw)
            return $urandom();
        return 32'(longint'($urandom_range(0, 3600000000)) - LON_LIM);
    endfunction

    // ---------------------------------------------------------------- checking
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (exp_dist_q.size() == 0)
            begin
                n_errors++;
                $display("unexpected result beat: distance_cm=%0d", distance_cm);
            end
            else
            begin
                if (distance_cm !== exp_dist_q[0])
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: distance_cm exp %0d got %0d",
                                 exp_dist_q[0], distance_cm);
                end
                void'(exp_dist_q.pop_front());
                n_checked++;
            end
        end
    end

    // ---------------------------------------------------------------- tests
    task automatic test_directed_points();
        send_pair(0, 0, 0, 0);
        send_pair(900000000, 0, -900000000, 0);
        send_pair(0, -1800000000, 0, 1800000000);
        send_pair(0, 0, 0, 1800000000);
        send_pair(450000000, 100000000, -450000000, -1700000000);
        send_pair(-900000000, 1800000000, 900000000, -1800000000);
        send_pair(515000000, -1200000, 515000010, -1200010);
        send_pair(31'sh3FFF_FFFF, 32'sh7FFF_FFFF, 31'sh4000_0000, 32'sh8000_0000);
        send_pair(31'sh4000_0000, 32'sh8000_0000, 31'sh3FFF_FFFF, 32'sh7FFF_FFFF);
        send_pair(31'sd1000000000, 0, -31'sd1000000000, 900000000);
        send_pair(-31'sd1, -32'sd1, 31'sd1, 32'sd1);
        send_pair(899999999, 1799999999, -899999999, -1799999999);
        send_pair(0, 900000000, 0, -900000000);
        send_pair(400000000, -740000000, 400000000, 1060000000);
    endtask

    task automatic test_radius_extremes();
        write_radius(24'd1);
        send_pair(0, 0, 0, 1800000000);
        send_pair(100000000, 0, 200000000, 0);
        write_radius(24'hFF_FFFF);
        send_pair(0, 0, 0, 1800000000);
        send_pair(900000000, 0, -900000000, 0);
        send_pair(31'sh4000_0000, 32'sh8000_0000, 31'sh3FFF_FFFF, 32'sh3FFF_FFFF);
        write_radius(24'd0);
        send_pair(0, 0, 0, 1800000000);
        send_pair(300000000, 10, -20, 1000);
        write_radius(24'd6371000);
    endtask

    task automatic test_random_pairs();
        logic signed [30:0] la;
        logic signed [31:0] oa;
        logic signed [30:0] lb;
        logic signed [31:0] ob;
        int kind;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 3)
                write_radius(RADIUS_W'($urandom_range(1, 24'hFF_FFFF)));
            if (n == 2 * N_RANDOM / 3)
                write_radius(24'($urandom()));
            kind = $urandom_range(0, 9);
            la = rand_lat(kind == 0);
            oa = rand_lon(kind == 0);
            lb = rand_lat(kind == 0);
            ob = rand_lon(kind == 0);
            if (kind == 1)
            begin
                lb = la + 31'($signed($urandom_range(0, 2000)) - 1000);
                ob = oa + 32'($signed($urandom_range(0, 2000)) - 1000);
            end
            else if (kind == 2)
            begin
                lb = -la;
                ob = oa + ((oa < 0) ? 32'sd1800000000 : -32'sd1800000000)
                        + 32'($signed($urandom_range(0, 20)) - 10);
            end
            send_pair(la, oa, lb, ob);
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        lat_a      = '0;
        lon_a      = '0;
        lat_b      = '0;
        lon_b      = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        radius_m   = 24'd6371000;
        n_mismatch = 0;
        n_errors   = 0;
        n_sent     = 0;
        n_checked  = 0;
        n_radius   = 0;
        burst_left = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_directed_points();
        test_radius_extremes();
        test_random_pairs();

        @(negedge clk);
        start = 1'b0;
        while (exp_dist_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        n_errors += exp_dist_q.size();

        $display("covered %0d point pairs, %0d checked, %0d radius writes incl. 0/1/max",
                 n_sent, n_checked, n_radius);
        $display("mismatches %0d, other errors %0d", n_mismatch, n_errors);
        if (n_mismatch == 0 && n_errors == 0)
            $display("PASS haversine_distance_core");
        else
            $display("FAIL haversine_distance_core");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout");
        $display("FAIL haversine_distance_core");
        $finish;
    end

endmodule

`default_nettype wire
